/* rtl/core/asf_pkg.sv */
// shared types, constants and coefficient tables for the atomic scattering factor unit
package asf_pkg;

	// payload of one input item and one result item
	typedef struct packed {
		logic [4:0]  atom_code;
		logic [15:0] q_value;
		logic [2:0]  hydrogen_count;
	} item_t;

	typedef struct packed {
		logic [23:0] form_factor;
		logic        unknown_type;
	} result_t;

	// configuration register indexes
	localparam logic REG_GRID_MODE  = 1'b0;
	localparam logic REG_EXPLICIT_H = 1'b1;

	// atom type codes
	localparam logic [4:0] ATOM_H   = 5'd0;
	localparam logic [4:0] ATOM_C   = 5'd1;
	localparam logic [4:0] ATOM_O   = 5'd2;
	localparam logic [4:0] ATOM_N   = 5'd3;
	localparam logic [4:0] ATOM_P   = 5'd4;
	localparam logic [4:0] ATOM_S   = 5'd5;
	localparam logic [4:0] ATOM_FE  = 5'd6;
	localparam logic [4:0] ATOM_CL  = 5'd7;
	localparam logic [4:0] ATOM_BR  = 5'd8;
	localparam logic [4:0] ATOM_NA  = 5'd9;
	localparam logic [4:0] ATOM_K   = 5'd10;
	localparam logic [4:0] ATOM_RB  = 5'd11;
	localparam logic [4:0] ATOM_MG  = 5'd12;
	localparam logic [4:0] ATOM_SR  = 5'd13;
	localparam logic [4:0] ATOM_OW  = 5'd14;
	localparam logic [4:0] ATOM_HW  = 5'd15;
	localparam logic [4:0] ATOM_EXE = 5'd16;
	localparam logic [4:0] ATOM_F   = 5'd17;
	localparam logic [4:0] ATOM_CA  = 5'd18;
	localparam logic [4:0] ATOM_I   = 5'd19;
	localparam logic [4:0] ATOM_CS  = 5'd20;
	localparam logic [4:0] ATOM_BA  = 5'd21;

	localparam int unsigned ROM_ROWS  = 14;
	localparam int unsigned NUM_TERMS = 6;
	localparam logic [3:0]  ROW_H     = 4'd0;
	localparam logic [3:0]  ROW_O     = 4'd2;

	// datapath widths
	localparam int unsigned S_W = 25;
	localparam int unsigned B_W = 25;
	localparam int unsigned A_W = 21;
	localparam int unsigned E_W = 33;

	// fixed-point constants
	localparam logic [24:0] KS_Q32     = 25'd27198198;
	localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
	localparam logic [31:0] LN2_Q32    = 32'd2977044472;
	localparam logic [11:0] DIGIT_DIV  = 12'd3125;
	localparam logic [33:0] X_DIV_MAX  = 34'd13107199999;
	localparam logic [22:0] RECIP_X    = 23'd5497558;
	localparam logic [6:0]  EXP_N_ZERO = 7'd33;
	localparam logic [31:0] OUT_HALF   = 32'd3276800000;
	localparam logic [40:0] OUT_R_MAX  = 41'd1677721599999;
	localparam logic [24:0] RECIP_OUT  = 25'd21990232;

	localparam logic [A_W-1:0] COEF_A [ROM_ROWS][NUM_TERMS] = '{
		'{21'd43028,   21'd28537,  21'd17134,  21'd9451,   21'd1725,   21'd114},
		'{21'd209921,  21'd180832, 21'd126159, 21'd56775,  21'd26303,  21'd10},
		'{21'd234752,  21'd183006, 21'd161538, 21'd152402, 21'd41423,  21'd26867},
		'{21'd245424,  21'd215782, 21'd105782, 21'd57557,  21'd44959,  21'd30480},
		'{21'd648197,  21'd431666, 21'd173759, 21'd135793, 21'd110559, 21'd10},
		'{21'd690565,  21'd524410, 21'd154516, 21'd142922, 21'd87564,  21'd10},
		'{21'd1118858, 21'd737206, 21'd355141, 21'd168125, 21'd120893, 21'd99652},
		'{21'd713932,  21'd634213, 21'd229801, 21'd197826, 21'd22854,  21'd983},
		'{21'd1472809, 21'd773340, 21'd408153, 21'd389920, 21'd284995, 21'd270412},
		'{21'd369529,  21'd330459, 21'd168333, 21'd69149,  21'd62431,  21'd88},
		'{21'd800372,  21'd744077, 21'd142217, 21'd113491, 21'd10,     21'd10},
		'{21'd1772736, 21'd770846, 21'd622707, 21'd423320, 21'd10456,  21'd10},
		'{21'd430385,  21'd258390, 21'd171397, 21'd139368, 21'd470,    21'd10},
		'{21'd1356253, 21'd915282, 21'd757461, 21'd423621, 21'd147524, 21'd10}
	};

	localparam logic [B_W-1:0] COEF_B [ROM_ROWS][NUM_TERMS] = '{
		'{25'd2302312, 25'd1020138, 25'd5125444, 25'd413511,  25'd135427,   25'd24269},
		'{25'd1318997, 25'd3037956, 25'd69255,   25'd16381,   25'd6842774,  25'd44083},
		'{25'd969710,  25'd1859876, 25'd519879,  25'd32408,   25'd3979099,  25'd1150},
		'{25'd1866694, 25'd831271,  25'd46989,   25'd4244646, 25'd8747,     25'd47126},
		'{25'd189537,  25'd2761455, 25'd50991,   25'd6628296, 25'd10,       25'd1205652},
		'{25'd146764,  25'd2231576, 25'd5606328, 25'd25588,   25'd10,       25'd2696892},
		'{25'd464599,  25'd30327,   25'd1207655, 25'd4415316, 25'd10411866, 25'd10},
		'{25'd118073,  25'd1952901, 25'd6104850, 25'd8057,    25'd2318225,  25'd9759},
		'{25'd187781,  25'd11285,   25'd2345650, 25'd365207,  25'd2150646,  25'd6850430},
		'{25'd324183,  25'd707179,  25'd12279,   25'd1545334, 25'd143664,   25'd3526383},
		'{25'd1270476, 25'd77473,   25'd10,      25'd3244270, 25'd19999900, 25'd8298298},
		'{25'd168258,  25'd9962,    25'd1334713, 25'd2564859, 25'd7690928,  25'd19999860},
		'{25'd402045,  25'd185304,  25'd10693,   25'd878523,  25'd5858712,  25'd12550050},
		'{25'd152639,  25'd1337893, 25'd9009,    25'd150827,  25'd2897999,  25'd16286130}
	};

endpackage

/* rtl/core/asf_exp_lane.sv */
// pipelined exp(-b*s) lane: scaling divide, base-2 split and eight-step polynomial
module asf_exp_lane (
	input  logic                         clk,
	input  logic [asf_pkg::S_W-1:0]      s,
	input  logic [asf_pkg::B_W-1:0]      b,
	output logic [asf_pkg::E_W-1:0]      e
);

	localparam int unsigned STEPS = 8;

	logic [49:0] prod_bs;
	logic [33:0] d_s1;
	logic [39:0] pp_hi_s2;
	logic [39:0] pp_lo_s2;
	logic [33:0] d_s2;
	logic [56:0] est_x;
	logic [22:0] q0_s3;
	logic [33:0] d_s3;
	logic [33:0] rem_x;
	logic [21:0] x_s4;
	logic [52:0] y_full;
	logic [6:0]  n_s5;
	logic [31:0] f_s5;
	logic [63:0] t_full;
	logic [31:0] t_s6;
	logic [6:0]  n_s6;

	// per-step pipeline registers, three stages per polynomial step
	logic [32:0] p_in    [STEPS];
	logic [31:0] t_in    [STEPS];
	logic [6:0]  n_in    [STEPS];
	logic [31:0] m_sa    [STEPS];
	logic [31:0] t_sa    [STEPS];
	logic [6:0]  n_sa    [STEPS];
	logic [31:0] m_sb    [STEPS];
	logic [31:0] quo_sb  [STEPS];
	logic [31:0] t_sb    [STEPS];
	logic [6:0]  n_sb    [STEPS];
	logic [32:0] p_sc    [STEPS];
	logic [31:0] t_sc    [STEPS];
	logic [6:0]  n_sc    [STEPS];

	assign prod_bs = b * s;
	assign est_x   = {pp_hi_s2, 17'b0} + 57'(pp_lo_s2);
	assign rem_x   = d_s3 - 34'(q0_s3) * 34'(asf_pkg::DIGIT_DIV);
	assign y_full  = x_s4 * asf_pkg::LOG2E_Q30;
	assign t_full  = f_s5 * asf_pkg::LN2_Q32;

	always_ff @(posedge clk) begin
		// anything past the clamp gives n >= 33 and so a zero exponential
		if (prod_bs[49:13] > 37'(asf_pkg::X_DIV_MAX)) begin
			d_s1 <= asf_pkg::X_DIV_MAX;
		end else begin
			d_s1 <= prod_bs[46:13];
		end
		pp_hi_s2 <= d_s1[33:17] * asf_pkg::RECIP_X;
		pp_lo_s2 <= d_s1[16:0] * asf_pkg::RECIP_X;
		d_s2     <= d_s1;
		q0_s3    <= est_x[56:34];
		d_s3     <= d_s2;
		if (rem_x >= 34'(asf_pkg::DIGIT_DIV)) begin
			x_s4 <= 22'(q0_s3 + 23'd1);
		end else begin
			x_s4 <= q0_s3[21:0];
		end
		n_s5 <= y_full[52:46];
		f_s5 <= y_full[45:14];
		t_s6 <= t_full[63:32];
		n_s6 <= n_s5;
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		localparam logic [3:0]  K  = 4'(STEPS - g);
		localparam logic [33:0] MK = 34'((64'd1 << 33) / (STEPS - g));

		logic [63:0] tp;
		logic [65:0] mq;
		logic [31:0] rem_k;
		logic [31:0] quo_fix;

		if (g == 0) begin : g_first
			assign p_in[g] = 33'h1_0000_0000;
			assign t_in[g] = t_s6;
			assign n_in[g] = n_s6;
		end else begin : g_next
			assign p_in[g] = p_sc[g-1];
			assign t_in[g] = t_sc[g-1];
			assign n_in[g] = n_sc[g-1];
		end

		assign tp      = 64'(t_in[g]) * 64'(p_in[g]);
		assign mq      = m_sa[g] * MK;
		assign rem_k   = m_sb[g] - 32'(quo_sb[g] * K);
		assign quo_fix = (rem_k >= 32'(K)) ? quo_sb[g] + 32'd1 : quo_sb[g];

		always_ff @(posedge clk) begin
			m_sa[g]   <= tp[63:32];
			t_sa[g]   <= t_in[g];
			n_sa[g]   <= n_in[g];
			quo_sb[g] <= mq[64:33];
			m_sb[g]   <= m_sa[g];
			t_sb[g]   <= t_sa[g];
			n_sb[g]   <= n_sa[g];
			p_sc[g]   <= 33'h1_0000_0000 - {1'b0, quo_fix};
			t_sc[g]   <= t_sb[g];
			n_sc[g]   <= n_sb[g];
		end
	end

	always_ff @(posedge clk) begin
		if (n_sc[STEPS-1] >= asf_pkg::EXP_N_ZERO) begin
			e <= '0;
		end else begin
			e <= p_sc[STEPS-1] >> n_sc[STEPS-1];
		end
	end

endmodule

/* rtl/core/atomic_scattering_factor_unit.sv */
// top level of the atomic scattering factor unit
// Takes one item per clock whenever start is high (busy is always low) and returns its
// form factor, strobed by done for one cycle; items may follow each other back to back
// with no gaps. The pipeline is made of the input stages, the twelve exp lanes, each of
// which spends 31 stages on the scaling divide, base-2 split and eight-step polynomial,
// and the summing and rounding divide at the end. The receiver cannot stall.
module atomic_scattering_factor_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  asf_pkg::item_t   item,
	output logic             done,
	output asf_pkg::result_t result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic             cfg_data
);

	localparam int unsigned LANE_LAT = 31;
	localparam int unsigned LANES    = 2 * asf_pkg::NUM_TERMS;
	localparam int unsigned PIPE_LAT = LANE_LAT + 9;

	typedef struct packed {
		logic       valid;
		logic       bad;
		logic       grid;
		logic       expl;
		logic [2:0] nh;
		logic [3:0] row;
		logic [5:0] count;
	} ctl_t;

	logic            grid_mode_q;
	logic            explicit_h_q;

	logic            valid_s1;
	logic [4:0]      code_s1;
	logic [2:0]      nh_s1;
	logic            grid_s1;
	logic            expl_s1;
	logic [31:0]     qq_s1;
	ctl_t            ctl_dec;
	ctl_t            ctl_s2;
	logic [56:0]     s_full;
	logic [asf_pkg::S_W-1:0] s_s2;

	ctl_t            ctl_lane_s [LANE_LAT];
	logic [asf_pkg::E_W-1:0] e_lane [LANES];

	ctl_t            ctl_s34;
	logic [53:0]     prod_s34 [LANES];
	ctl_t            ctl_s35;
	logic [56:0]     rsum_s35;
	logic [56:0]     hsum_s35;
	logic [56:0]     rsum;
	logic [56:0]     hsum;
	ctl_t            ctl_s36;
	logic [60:0]     raw_s36;
	ctl_t            ctl_s37;
	logic [61:0]     rounded;
	logic [35:0]     r3_s37;
	ctl_t            ctl_s38;
	logic [42:0]     pp_hi_s38;
	logic [42:0]     pp_lo_s38;
	logic [35:0]     r3_s38;
	ctl_t            ctl_s39;
	logic [24:0]     q0_s39;
	logic [35:0]     r3_s39;
	logic [60:0]     est_out;
	logic [35:0]     rem_out;
	logic [23:0]     ff_table;
	logic            done_s40;
	asf_pkg::result_t result_s40;

	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_mode_q  <= 1'b0;
			explicit_h_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				asf_pkg::REG_GRID_MODE:  grid_mode_q  <= cfg_data;
				asf_pkg::REG_EXPLICIT_H: explicit_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: capture item and mode, square q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		code_s1 <= item.atom_code;
		nh_s1   <= item.hydrogen_count;
		grid_s1 <= grid_mode_q;
		expl_s1 <= explicit_h_q;
		qq_s1   <= item.q_value * item.q_value;
	end

	// type decode
	always_comb begin
		ctl_dec       = '0;
		ctl_dec.valid = valid_s1;
		ctl_dec.grid  = grid_s1;
		ctl_dec.expl  = expl_s1;
		ctl_dec.nh    = nh_s1;
		ctl_dec.row   = asf_pkg::ROW_H;
		if (grid_s1) begin
			unique case (code_s1) inside
				asf_pkg::ATOM_EXE: ctl_dec.count = 6'd1;
				asf_pkg::ATOM_HW: begin
					if (expl_s1) begin
						ctl_dec.count = 6'd1;
					end else begin
						ctl_dec.bad = 1'b1;
					end
				end
				asf_pkg::ATOM_OW: ctl_dec.count = expl_s1 ? 6'd8 : 6'd10;
				asf_pkg::ATOM_F, asf_pkg::ATOM_NA, asf_pkg::ATOM_MG: ctl_dec.count = 6'd10;
				asf_pkg::ATOM_CL, asf_pkg::ATOM_K, asf_pkg::ATOM_CA: ctl_dec.count = 6'd18;
				asf_pkg::ATOM_BR, asf_pkg::ATOM_RB, asf_pkg::ATOM_SR: ctl_dec.count = 6'd36;
				asf_pkg::ATOM_I, asf_pkg::ATOM_CS, asf_pkg::ATOM_BA: ctl_dec.count = 6'd54;
				default: ctl_dec.bad = 1'b1;
			endcase
		end else begin
			if (code_s1 <= asf_pkg::ATOM_SR) begin
				ctl_dec.row = code_s1[3:0];
			end else if (code_s1 == asf_pkg::ATOM_OW) begin
				ctl_dec.row = asf_pkg::ROW_O;
			end else if (code_s1 == asf_pkg::ATOM_HW) begin
				ctl_dec.row = asf_pkg::ROW_H;
			end else begin
				ctl_dec.bad = 1'b1;
			end
		end
	end

	// stage 2: s = q^2 / (16 pi^2)
	assign s_full = qq_s1 * asf_pkg::KS_Q32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_dec;
		end
	end

	always_ff @(posedge clk) begin
		s_s2 <= s_full[56:32];
	end

	// six lanes for the atom row, six for the hydrogen row
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		localparam int unsigned TERM = l % asf_pkg::NUM_TERMS;
		logic [3:0] row_b;
		assign row_b = (l < asf_pkg::NUM_TERMS) ? ctl_s2.row : asf_pkg::ROW_H;

		asf_exp_lane u_lane (
			.clk (clk),
			.s   (s_s2),
			.b   (asf_pkg::COEF_B[row_b][TERM]),
			.e   (e_lane[l])
		);
	end

	// control rides alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++) begin
				ctl_lane_s[i] <= '0;
			end
		end else begin
			ctl_lane_s[0] <= ctl_s2;
			for (int i = 1; i < LANE_LAT; i++) begin
				ctl_lane_s[i] <= ctl_lane_s[i-1];
			end
		end
	end

	// stage 34: weight each exponential by its amplitude
	for (genvar l = 0; l < LANES; l++) begin : g_amp
		localparam int unsigned TERM = l % asf_pkg::NUM_TERMS;
		logic [3:0] row_a;
		assign row_a = (l < asf_pkg::NUM_TERMS) ? ctl_lane_s[LANE_LAT-1].row : asf_pkg::ROW_H;

		always_ff @(posedge clk) begin
			prod_s34[l] <= asf_pkg::COEF_A[row_a][TERM] * e_lane[l];
		end
	end

	always_comb begin
		rsum = '0;
		hsum = '0;
		for (int i = 0; i < asf_pkg::NUM_TERMS; i++) begin
			rsum = rsum + 57'(prod_s34[i]);
			hsum = hsum + 57'(prod_s34[i + asf_pkg::NUM_TERMS]);
		end
	end

	assign rounded = 62'(raw_s36) + 62'(asf_pkg::OUT_HALF);
	assign est_out = {pp_hi_s38, 18'b0} + 61'(pp_lo_s38);
	assign rem_out = r3_s39 - 36'(q0_s39) * 36'(asf_pkg::DIGIT_DIV);
	assign ff_table = (rem_out >= 36'(asf_pkg::DIGIT_DIV)) ? 24'(q0_s39 + 25'd1) : q0_s39[23:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s34  <= '0;
			ctl_s35  <= '0;
			ctl_s36  <= '0;
			ctl_s37  <= '0;
			ctl_s38  <= '0;
			ctl_s39  <= '0;
			done_s40 <= 1'b0;
		end else begin
			ctl_s34  <= ctl_lane_s[LANE_LAT-1];
			ctl_s35  <= ctl_s34;
			ctl_s36  <= ctl_s35;
			ctl_s37  <= ctl_s36;
			ctl_s38  <= ctl_s37;
			ctl_s39  <= ctl_s38;
			done_s40 <= ctl_s39.valid;
		end
	end

	always_ff @(posedge clk) begin
		rsum_s35 <= rsum;
		hsum_s35 <= hsum;
		if (ctl_s35.expl) begin
			raw_s36 <= 61'(rsum_s35);
		end else begin
			raw_s36 <= 61'(rsum_s35) + 61'(ctl_s35.nh * hsum_s35);
		end
		// saturate, then drop the power-of-two part of the output scale
		if (rounded[61:16] > 46'(asf_pkg::OUT_R_MAX)) begin
			r3_s37 <= asf_pkg::OUT_R_MAX[40:5];
		end else begin
			r3_s37 <= rounded[56:21];
		end
		pp_hi_s38 <= r3_s37[35:18] * asf_pkg::RECIP_OUT;
		pp_lo_s38 <= r3_s37[17:0] * asf_pkg::RECIP_OUT;
		r3_s38    <= r3_s37;
		q0_s39    <= est_out[60:36];
		r3_s39    <= r3_s38;
		if (ctl_s39.bad) begin
			result_s40.form_factor  <= '0;
			result_s40.unknown_type <= 1'b1;
		end else if (ctl_s39.grid) begin
			result_s40.form_factor  <= {2'b0, ctl_s39.count, 16'b0};
			result_s40.unknown_type <= 1'b0;
		end else begin
			result_s40.form_factor  <= ff_table;
			result_s40.unknown_type <= 1'b0;
		end
	end

	assign done   = done_s40;
	assign result = result_s40;

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##PIPE_LAT done)
		else $error("item did not come out after the pipeline latency");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.unknown_type |-> result.form_factor == '0)
		else $error("unknown type with nonzero factor");

	a_grid_integer: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.unknown_type && $past(ctl_s39.grid) |-> result.form_factor[15:0] == '0)
		else $error("grid count has fraction bits");

endmodule

/* test/asf_scoreboard.sv */
// scoreboard class for the atomic scattering factor unit testbench
`timescale 1ns / 100ps

class asf_scoreboard;
	asf_pkg::result_t expected_q[$];
	bit grid_mode;
	bit explicit_h;
	int unsigned fail_count;

	// coefficient rows in units of 1e-5
	longint unsigned coef_a[14][6] = '{
		'{43028, 28537, 17134, 9451, 1725, 114},
		'{209921, 180832, 126159, 56775, 26303, 10},
		'{234752, 183006, 161538, 152402, 41423, 26867},
		'{245424, 215782, 105782, 57557, 44959, 30480},
		'{648197, 431666, 173759, 135793, 110559, 10},
		'{690565, 524410, 154516, 142922, 87564, 10},
		'{1118858, 737206, 355141, 168125, 120893, 99652},
		'{713932, 634213, 229801, 197826, 22854, 983},
		'{1472809, 773340, 408153, 389920, 284995, 270412},
		'{369529, 330459, 168333, 69149, 62431, 88},
		'{800372, 744077, 142217, 113491, 10, 10},
		'{1772736, 770846, 622707, 423320, 10456, 10},
		'{430385, 258390, 171397, 139368, 470, 10},
		'{1356253, 915282, 757461, 423621, 147524, 10}
	};
	longint unsigned coef_b[14][6] = '{
		'{2302312, 1020138, 5125444, 413511, 135427, 24269},
		'{1318997, 3037956, 69255, 16381, 6842774, 44083},
		'{969710, 1859876, 519879, 32408, 3979099, 1150},
		'{1866694, 831271, 46989, 4244646, 8747, 47126},
		'{189537, 2761455, 50991, 6628296, 10, 1205652},
		'{146764, 2231576, 5606328, 25588, 10, 2696892},
		'{464599, 30327, 1207655, 4415316, 10411866, 10},
		'{118073, 1952901, 6104850, 8057, 2318225, 9759},
		'{187781, 11285, 2345650, 365207, 2150646, 6850430},
		'{324183, 707179, 12279, 1545334, 143664, 3526383},
		'{1270476, 77473, 10, 3244270, 19999900, 8298298},
		'{168258, 9962, 1334713, 2564859, 7690928, 19999860},
		'{402045, 185304, 10693, 878523, 5858712, 12550050},
		'{152639, 1337893, 9009, 150827, 2897999, 16286130}
	};

	function void set_register(bit index, bit value);
		if (index == asf_pkg::REG_GRID_MODE) grid_mode = value;
		else explicit_h = value;
	endfunction

	// exp(-x), x in Q.16, result in Q0.32
	function longint unsigned exp_decay(longint unsigned x);
		longint unsigned y, n, f, t, p;
		y = x * 64'd1549082005;
		n = y >> 46;
		f = (y >> 14) & 64'hFFFF_FFFF;
		t = (f * 64'd2977044472) >> 32;
		p = 64'd1 << 32;
		if (n >= 33) return 0;
		for (int k = 8; k >= 1; k--)
			p = (64'd1 << 32) - ((t * p) >> 32) / k;
		return p >> n;
	endfunction

	function longint unsigned gauss_total(int row, longint unsigned s);
		longint unsigned acc;
		acc = 0;
		for (int i = 0; i < 6; i++)
			acc += coef_a[row][i] * exp_decay((coef_b[row][i] * s) / 64'd25600000);
		return acc;
	endfunction

	function asf_pkg::result_t form_factor_of(asf_pkg::item_t it);
		asf_pkg::result_t r;
		longint unsigned s, raw, v, q;
		int row;
		r = '0;
		r.unknown_type = 1'b0;
		if (grid_mode) begin
			v = 0;
			case (it.atom_code)
				asf_pkg::ATOM_EXE: v = 1;
				asf_pkg::ATOM_HW: v = explicit_h ? 1 : 0;
				asf_pkg::ATOM_OW: v = explicit_h ? 8 : 10;
				asf_pkg::ATOM_F, asf_pkg::ATOM_NA, asf_pkg::ATOM_MG: v = 10;
				asf_pkg::ATOM_CL, asf_pkg::ATOM_K, asf_pkg::ATOM_CA: v = 18;
				asf_pkg::ATOM_BR, asf_pkg::ATOM_RB, asf_pkg::ATOM_SR: v = 36;
				asf_pkg::ATOM_I, asf_pkg::ATOM_CS, asf_pkg::ATOM_BA: v = 54;
				default: v = 0;
			endcase
			if (v == 0) r.unknown_type = 1'b1;
			else r.form_factor = 24'(v << 16);
		end else if (it.atom_code > asf_pkg::ATOM_HW) begin
			r.unknown_type = 1'b1;
		end else begin
			if (it.atom_code == asf_pkg::ATOM_OW) row = asf_pkg::ROW_O;
			else if (it.atom_code == asf_pkg::ATOM_HW) row = asf_pkg::ROW_H;
			else row = it.atom_code;
			q = it.q_value;
			s = ((q * q) * 64'd27198198) >> 32;
			raw = gauss_total(row, s);
			if (!explicit_h) raw += it.hydrogen_count * gauss_total(0, s);
			v = (raw + 64'd3276800000) / 64'd6553600000;
			if (v > 64'hFF_FFFF) v = 64'hFF_FFFF;
			r.form_factor = 24'(v);
		end
		return r;
	endfunction

	function void note_item(asf_pkg::item_t it);
		expected_q = {expected_q, form_factor_of(it)};
	endfunction

	function void check_result(asf_pkg::result_t got);
		asf_pkg::result_t exp_r;
		if (expected_q.size() == 0) begin
			$error("unexpected result %h", got);
			fail_count++;
			return;
		end
		exp_r = expected_q.pop_front();
		if (got.form_factor !== exp_r.form_factor) begin
			$error("form_factor expected %0d actual %0d", exp_r.form_factor, got.form_factor);
			fail_count++;
		end
		if (got.unknown_type !== exp_r.unknown_type) begin
			$error("unknown_type expected %0d actual %0d", exp_r.unknown_type,
				got.unknown_type);
			fail_count++;
		end
	endfunction
endclass

/* test/tb_atomic_scattering_factor_unit.sv */
// testbench top for the atomic scattering factor unit
`timescale 1ns / 100ps

module tb_atomic_scattering_factor_unit;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	asf_pkg::item_t item = '0;
	logic done;
	asf_pkg::result_t result;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic cfg_data = 1'b0;

	asf_scoreboard factor_board = new();

	atomic_scattering_factor_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy) factor_board.note_item(item);
		if (arst_n && done) factor_board.check_result(result);
	end

	task automatic send_item(input logic [4:0] code, input logic [15:0] q,
			input logic [2:0] nh);
		asf_pkg::item_t it;
		it.atom_code = code;
		it.q_value = q;
		it.hydrogen_count = nh;
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		// occasional gap, mostly short
		if ($urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3))
				@(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (factor_board.expected_q.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_reg(input logic index, input logic value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		factor_board.set_register(index, value);
	endtask

	task automatic random_item();
		logic [4:0] code;
		logic [15:0] q;
		code = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 21));
		case ($urandom_range(0, 3))
			0: q = 16'($urandom);
			1: q = 16'($urandom_range(0, 8191));
			2: q = 16'($urandom_range(0, 1023));
			default: q = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		endcase
		send_item(code, q, 3'($urandom));
	endtask

	initial begin
		logic [3:0] modes;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(asf_pkg::REG_GRID_MODE, 1'b0);
		write_reg(asf_pkg::REG_EXPLICIT_H, 1'b0);
		// directed: field extremes, water and unknown codes
		send_item(asf_pkg::ATOM_H, 16'h0000, 3'd0);
		send_item(asf_pkg::ATOM_C, 16'hFFFF, 3'd7);
		send_item(asf_pkg::ATOM_FE, 16'h0000, 3'd7);
		send_item(asf_pkg::ATOM_OW, 16'h1000, 3'd2);
		send_item(asf_pkg::ATOM_HW, 16'h0800, 3'd1);
		send_item(asf_pkg::ATOM_SR, 16'h2000, 3'd3);
		send_item(asf_pkg::ATOM_EXE, 16'h1234, 3'd1);
		send_item(asf_pkg::ATOM_BA, 16'h0100, 3'd0);
		send_item(5'd31, 16'hAAAA, 3'd5);
		send_item(5'd22, 16'h5555, 3'd2);
		drain();
		write_reg(asf_pkg::REG_GRID_MODE, 1'b1);
		for (int c = 0; c < 24; c++) send_item(5'(c), 16'($urandom), 3'($urandom));
		drain();
		write_reg(asf_pkg::REG_EXPLICIT_H, 1'b1);
		send_item(asf_pkg::ATOM_OW, 16'h0000, 3'd7);
		send_item(asf_pkg::ATOM_HW, 16'hFFFF, 3'd0);
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			modes = 4'($urandom);
			write_reg(asf_pkg::REG_GRID_MODE, modes[0]);
			write_reg(asf_pkg::REG_EXPLICIT_H, modes[1]);
			repeat (60) random_item();
			drain();
		end
		if (factor_board.fail_count == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
